FILE: rtl/bpac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpac_pkg;

  // fixed field widths
  localparam int IDX_W      = 12;
  localparam int SCORE_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int CUT_W      = 7;
  localparam int TOPK_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [TOPK_W-1:0] TOP_K_RESET = 16'd100;

  // input item
  typedef struct packed {
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
    logic [SCORE_W-1:0] pair_score;
  } in_item_t;

  // result item
  typedef struct packed {
    logic             improved;
    logic [CUT_W-1:0] cutoff_now;
  } out_item_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_K        = 1'b0,
    REG_START_CUTOFF = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RB_RD,
    ST_RB_WR,
    ST_H_RD,
    ST_H_WR,
    ST_A_RD,
    ST_A_WR,
    ST_B_RD,
    ST_B_WR,
    ST_DONE
  } seq_state_t;

  // shared unit request and response
  typedef struct packed {
    logic [CNT_W-1:0] add_a;
    logic [CNT_W-1:0] add_b;
    logic [CNT_W-1:0] cmp_a;
    logic [CNT_W-1:0] cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/bpac_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/bpac_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module bpac_alu
  import bpac_pkg::*;
(
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic [CNT_W:0] raw_sum;

  // saturating add and greater-than compare
  always_comb begin
    raw_sum = {1'b0, req.add_a} + {1'b0, req.add_b};
    rsp.sum = raw_sum[CNT_W] ? CNT_MAX : raw_sum[CNT_W-1:0];
    rsp.gt  = req.cmp_a > req.cmp_b;
  end

endmodule

`default_nettype wire

FILE: rtl/best_partner_adaptive_cutoff_unit.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid / in_stall   | in_item_t  (first, second, score)
// out_    | output    | out_valid / out_stall | out_item_t (improved, cutoff_now)
// cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// an item passes ST_H_RD, ST_H_WR (only if its score is above the cutoff), ST_A_RD, ST_A_WR,
// ST_B_RD, ST_B_WR and ST_DONE, which waits while the output register is full and stalled;
// the partner memory is read twice per item; every ROLLOVER items a suffix rebuild runs first
// after reset, clearing max(NUM_ELEMENTS, TOP_BIN + 1) addresses keeps in_stall high
// reset is synchronous, active low; config writes are taken at any time
// a finished result waits in the output register while the next item is accepted
`timescale 1ns / 1ps
`default_nettype none

module best_partner_adaptive_cutoff_unit
  import bpac_pkg::*;
#(
  parameter int NUM_ELEMENTS = 4096,
  parameter int TOP_BIN      = 64,
  parameter int ROLLOVER     = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PAW     = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int HDEPTH  = TOP_BIN + 1;
  localparam int HAW     = $clog2(HDEPTH);
  localparam int CLR_LEN = (NUM_ELEMENTS > HDEPTH) ? NUM_ELEMENTS : HDEPTH;
  localparam int CLRW    = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
  localparam int TW      = $clog2(ROLLOVER + 1);
  localparam int HW      = 2 * CNT_W;
  localparam int PW      = IDX_W + SCORE_W;

  seq_state_t        state_r, state_nxt;
  logic [CLRW-1:0]   clr_cnt_r, clr_cnt_nxt;
  in_item_t          item_r, item_nxt;
  logic              imp_r, imp_nxt;
  logic [HAW-1:0]    cutoff_r, cutoff_nxt;
  logic [TW-1:0]     timer_r, timer_nxt;
  logic [HAW-1:0]    rb_bin_r, rb_bin_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [TOPK_W-1:0] top_k_r, top_k_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              p_we;
  logic [PAW-1:0]    p_waddr, p_raddr;
  logic [PW-1:0]     p_wdata, p_rdata;
  logic              h_we;
  logic [HAW-1:0]    h_waddr, h_raddr;
  logic [HW-1:0]     h_wdata, h_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic [FRAC_W-1:0]      score_hi;
  logic [HAW-1:0]         bin_sel;
  logic [PAW+IDX_W-1:0]   a_wide, b_wide;
  logic [PAW-1:0]         a_addr, b_addr;
  logic                   a_ok, b_ok;
  logic [SCORE_W-1:0]     stored_score;
  logic [CNT_W-1:0]       h_bin, h_sfx, sfx_new;
  logic [CUT_W-1:0]       start_val;

  // partner memory: {partner, score}
  bpac_ram #(.WIDTH(PW), .DEPTH(NUM_ELEMENTS), .AW(PAW)) u_partner_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // histogram memory: {bin count, suffix count}
  bpac_ram #(.WIDTH(HW), .DEPTH(HDEPTH), .AW(HAW)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  bpac_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // item decode
  always_comb begin
    score_hi     = item_r.pair_score[SCORE_W-1:FRAC_W];
    bin_sel      = ({1'b0, score_hi} > 9'(TOP_BIN)) ? HAW'(TOP_BIN) : HAW'(score_hi);
    a_wide       = (PAW+IDX_W)'(item_r.first_index);
    b_wide       = (PAW+IDX_W)'(item_r.second_index);
    a_addr       = a_wide[PAW-1:0];
    b_addr       = b_wide[PAW-1:0];
    a_ok         = 32'(item_r.first_index) < 32'(NUM_ELEMENTS);
    b_ok         = 32'(item_r.second_index) < 32'(NUM_ELEMENTS);
    stored_score = p_rdata[SCORE_W-1:0];
    h_bin        = h_rdata[HW-1:CNT_W];
    h_sfx        = h_rdata[CNT_W-1:0];
    start_val    = cfg_wdata[CUT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    imp_nxt       = imp_r;
    cutoff_nxt    = cutoff_r;
    timer_nxt     = timer_r;
    rb_bin_nxt    = rb_bin_r;
    acc_nxt       = acc_r;
    top_k_nxt     = top_k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    p_we          = 1'b0;
    p_waddr       = a_addr;
    p_wdata       = {item_r.second_index, item_r.pair_score};
    p_raddr       = a_addr;
    h_we          = 1'b0;
    h_waddr       = bin_sel;
    h_wdata       = {h_bin, h_sfx};
    h_raddr       = bin_sel;
    alu_req       = '0;
    sfx_new       = h_bin;

    unique case (state_r)
      // zero both memories after reset
      ST_CLEAR: begin
        p_we    = 32'(clr_cnt_r) < 32'(NUM_ELEMENTS);
        p_waddr = clr_cnt_r[PAW-1:0];
        p_wdata = '0;
        h_we    = 32'(clr_cnt_r) < 32'(HDEPTH);
        h_waddr = clr_cnt_r[HAW-1:0];
        h_wdata = '0;
        if (clr_cnt_r == CLRW'(CLR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          imp_nxt  = 1'b0;
          if (timer_r == TW'(ROLLOVER)) begin
            timer_nxt  = '0;
            rb_bin_nxt = HAW'(TOP_BIN);
            acc_nxt    = '0;
            state_nxt  = ST_RB_RD;
          end else begin
            state_nxt = ST_H_RD;
          end
        end
      end

      // suffix rebuild, top bin downwards
      ST_RB_RD: begin
        h_raddr   = rb_bin_r;
        state_nxt = ST_RB_WR;
      end

      ST_RB_WR: begin
        alu_req.add_a = acc_r;
        alu_req.add_b = h_bin;
        if (rb_bin_r >= cutoff_r) begin
          sfx_new = alu_rsp.sum;
          acc_nxt = alu_rsp.sum;
        end
        h_we    = 1'b1;
        h_waddr = rb_bin_r;
        h_wdata = {h_bin, sfx_new};
        if (rb_bin_r == '0) begin
          state_nxt = ST_H_RD;
        end else begin
          rb_bin_nxt = rb_bin_r - 1'b1;
          state_nxt  = ST_RB_RD;
        end
      end

      // cutoff test alongside the histogram read
      ST_H_RD: begin
        alu_req.cmp_a = 32'(item_r.pair_score);
        alu_req.cmp_b = 32'({8'(cutoff_r), {FRAC_W{1'b0}}});
        h_raddr       = bin_sel;
        state_nxt     = alu_rsp.gt ? ST_H_WR : ST_A_RD;
      end

      ST_H_WR: begin
        alu_req.add_a = h_bin;
        alu_req.add_b = 32'd1;
        h_we          = 1'b1;
        h_waddr       = bin_sel;
        h_wdata       = {alu_rsp.sum, h_sfx};
        if (alu_rsp.sum >= 32'(top_k_r) || h_sfx >= 32'(top_k_r)) begin
          cutoff_nxt = bin_sel;
        end
        state_nxt = ST_A_RD;
      end

      // first element's entry
      ST_A_RD: begin
        p_raddr   = a_addr;
        state_nxt = ST_A_WR;
      end

      ST_A_WR: begin
        alu_req.cmp_a = 32'(item_r.pair_score);
        alu_req.cmp_b = 32'(stored_score);
        p_waddr       = a_addr;
        p_wdata       = {item_r.second_index, item_r.pair_score};
        if (alu_rsp.gt && a_ok) begin
          p_we    = 1'b1;
          imp_nxt = 1'b1;
        end
        state_nxt = ST_B_RD;
      end

      // second element's entry, sees the first write
      ST_B_RD: begin
        p_raddr   = b_addr;
        state_nxt = ST_B_WR;
      end

      ST_B_WR: begin
        alu_req.cmp_a = 32'(item_r.pair_score);
        alu_req.cmp_b = 32'(stored_score);
        p_waddr       = b_addr;
        p_wdata       = {item_r.first_index, item_r.pair_score};
        if (alu_rsp.gt && b_ok) begin
          p_we    = 1'b1;
          imp_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.improved   = imp_r;
          out_data_nxt.cutoff_now = CUT_W'(cutoff_r);
          if (timer_r != TW'(ROLLOVER)) begin
            timer_nxt = timer_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TOP_K: begin
          top_k_nxt = cfg_wdata[TOPK_W-1:0];
        end
        REG_START_CUTOFF: begin
          cutoff_nxt = (32'(start_val) > 32'(TOP_BIN)) ? HAW'(TOP_BIN) : HAW'(start_val);
        end
        default: begin
          top_k_nxt = top_k_r;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cutoff_r    <= '0;
      timer_r     <= '0;
      top_k_r     <= TOP_K_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cutoff_r    <= cutoff_nxt;
      timer_r     <= timer_nxt;
      top_k_r     <= top_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    imp_r      <= imp_nxt;
    rb_bin_r   <= rb_bin_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/bpac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bpac_checker
  import bpac_pkg::*;
#(
  parameter int TOP_BIN = 64
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // cutoff never beyond the top bin
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.cutoff_now) <= 32'(TOP_BIN))
    else $error("cutoff above top bin");

  // memories are being cleared right after reset
  assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> in_stall)
    else $error("item taken during clearing pass");

  // one item at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is at work");

endmodule

bind best_partner_adaptive_cutoff_unit bpac_checker #(.TOP_BIN(TOP_BIN)) u_bpac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
